// File: design/dpfm_pkg.sv
// Package: shared widths, register indexes, reset values and status type for the flow meter.
package dpfm_pkg;

	localparam int unsigned CNT_W     = 32;
	localparam int unsigned ML_W      = 16;
	localparam int unsigned TICKS_W   = 16;
	localparam int unsigned STALE_W   = 24;
	localparam int unsigned FLOW_W    = 26;
	localparam int unsigned CFG_W     = 24;
	localparam int unsigned CFG_IDX_W = 3;

	localparam int unsigned TICK_RATE_DEF = 1000;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ML_PER_PULSE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSE_RISE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT = 3'd5;

	localparam logic [ML_W-1:0]    ML_RST     = 16'd1000;
	localparam logic [TICKS_W-1:0] WIDTH_RST  = 16'd10;
	localparam logic [TICKS_W-1:0] PERIOD_RST = 16'd100;
	localparam logic [STALE_W-1:0] STALE_RST  = 24'd60000;
	localparam logic [TICKS_W:0]   HOLD_EXTRA = 17'd10;

	localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

	typedef struct packed {
		logic [CNT_W-1:0]   pulse_count;
		logic [CNT_W-1:0]   last_tick;
		logic [CNT_W-1:0]   prior_tick;
		logic [CNT_W-1:0]   tick_cnt;
		logic [ML_W-1:0]    ml_per_pulse;
		logic [STALE_W-1:0] stale_limit;
		logic               counted;
		logic               armed;
	} tick_stat_t;

endpackage

// File: design/dpfm_in_if.sv
// Interface: input tick channel carrying the meter pin level.
interface dpfm_in_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

// File: design/dpfm_out_if.sv
// Interface: result channel carrying pulse total, flow and status.
interface dpfm_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pulse_total;
	logic [25:0] flow_ml_per_s;
	logic        pulse_counted;
	logic        armed;

	modport source (output valid, output pulse_total, output flow_ml_per_s,
		output pulse_counted, output armed, input ready);
	modport sink (input valid, input pulse_total, input flow_ml_per_s,
		input pulse_counted, input armed, output ready);
endinterface

// File: design/dpfm_tick.sv
// Tick state: configuration registers, debounce phase machine, timestamps and pulse count.
module dpfm_tick
	import dpfm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 step,
	input  logic                 pin,
	input  logic                 advance,
	output tick_stat_t           stat
);

	typedef enum logic [1:0] {
		PH_ARMED  = 2'd0,
		PH_WIDTH  = 2'd1,
		PH_PERIOD = 2'd2
	} phase_t;

	phase_t              phase_q;
	logic [TICKS_W-1:0]  timer_q;
	logic [CNT_W-1:0]    tick_q;
	logic [CNT_W-1:0]    last_q;
	logic [CNT_W-1:0]    prior_q;
	logic [CNT_W-1:0]    count_q;
	logic                prev_pin_q;
	logic                counted_q;
	logic                enable_q;
	logic [ML_W-1:0]     ml_q;
	logic [TICKS_W-1:0]  width_q;
	logic [TICKS_W-1:0]  period_q;
	logic                sense_q;
	logic [STALE_W-1:0]  stale_q;

	logic               active;
	logic               was_active;
	logic [TICKS_W:0]   hold_sum;
	logic [TICKS_W-1:0] holdoff;

	assign active     = (pin == sense_q);
	assign was_active = (prev_pin_q == sense_q);
	assign hold_sum   = {1'b0, width_q} + HOLD_EXTRA;

	always_comb begin
		holdoff = period_q;
		if (period_q <= width_q) begin
			holdoff = hold_sum[TICKS_W] ? {TICKS_W{1'b1}} : hold_sum[TICKS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ARMED;
			timer_q    <= '0;
			tick_q     <= '0;
			last_q     <= '0;
			prior_q    <= '0;
			count_q    <= '0;
			prev_pin_q <= 1'b0;
			counted_q  <= 1'b0;
			enable_q   <= 1'b0;
			ml_q       <= ML_RST;
			width_q    <= WIDTH_RST;
			period_q   <= PERIOD_RST;
			sense_q    <= 1'b1;
			stale_q    <= STALE_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_ENABLE: begin
						enable_q <= cfg_data[0];
						if (cfg_data[0]) begin
							last_q  <= tick_q;
							prior_q <= tick_q;
							phase_q <= PH_ARMED;
							timer_q <= '0;
						end
					end
					CFG_ML_PER_PULSE: ml_q     <= cfg_data[ML_W-1:0];
					CFG_PULSE_WIDTH:  width_q  <= cfg_data[TICKS_W-1:0];
					CFG_PERIOD:       period_q <= cfg_data[TICKS_W-1:0];
					CFG_SENSE_RISE:   sense_q  <= cfg_data[0];
					CFG_STALE_LIMIT:  stale_q  <= cfg_data[STALE_W-1:0];
					default: ;
				endcase
			end
			if (step) begin
				counted_q  <= (phase_q == PH_WIDTH) && (timer_q <= 16'd1) && active;
				prev_pin_q <= pin;
				case (phase_q)
					PH_WIDTH: begin
						if (timer_q <= 16'd1) begin
							if (active) begin
								count_q <= count_q + 32'd1;
								prior_q <= last_q;
								last_q  <= tick_q;
								phase_q <= PH_PERIOD;
								timer_q <= holdoff;
							end else begin
								timer_q <= '0;
								phase_q <= PH_ARMED;
							end
						end else begin
							timer_q <= timer_q - 16'd1;
						end
					end
					PH_PERIOD: begin
						if (timer_q <= 16'd1) begin
							timer_q <= '0;
							phase_q <= PH_ARMED;
						end else begin
							timer_q <= timer_q - 16'd1;
						end
					end
					default: begin
						if (enable_q && active && !was_active) begin
							phase_q <= PH_WIDTH;
							timer_q <= width_q;
						end else begin
							phase_q <= PH_ARMED;
						end
					end
				endcase
			end
			if (advance) begin
				tick_q <= tick_q + 32'd1;
			end
		end
	end

	assign stat.pulse_count  = count_q;
	assign stat.last_tick    = last_q;
	assign stat.prior_tick   = prior_q;
	assign stat.tick_cnt     = tick_q;
	assign stat.ml_per_pulse = ml_q;
	assign stat.stale_limit  = stale_q;
	assign stat.counted      = counted_q;
	assign stat.armed        = (phase_q == PH_ARMED);

endmodule

// File: design/dpfm_div.sv
// Restoring divider: one quotient bit per cycle.
module dpfm_div
	import dpfm_pkg::*;
#(
	parameter int unsigned DVD_W = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	localparam int unsigned STEP_W = $clog2(DVD_W + 1);

	logic [STEP_W-1:0] cnt_q;
	logic [DVD_W-1:0]  dq_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;

	logic [CNT_W:0]   rem_sh;
	logic [CNT_W+1:0] diff;

	assign rem_sh = {rem_q, dq_q[DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEP_W'(DVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[CNT_W+1]) begin
				rem_q <= diff[CNT_W-1:0];
				dq_q  <= {dq_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[CNT_W-1:0];
				dq_q  <= {dq_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = dq_q;

endmodule

// File: design/debounced_pulse_flow_meter.sv
// Top level: debounced pulse counter with period-based flow rate and result register.
//
//  channel   dir  payload                                               transfer
//  in_ch     in   pin_level                                             valid & ready
//  out_ch    out  pulse_total, flow_ml_per_s, pulse_counted, armed      valid & ready
//  cfg       in   cfg_idx, cfg_data                                     cfg_we
//
// Each transaction runs through S_PREP, S_LOAD, S_DIV and S_DONE; in S_DIV the
// serial divider produces one quotient bit per cycle.
// in_ch.ready is high only while the sequencer is idle.
// A finished result waits in the output register; a new transaction is taken meanwhile.
// Reset is asynchronous; counters, timestamps, config and state take their defaults.
module debounced_pulse_flow_meter
	import dpfm_pkg::*;
#(
	parameter int unsigned TICK_RATE_HZ = TICK_RATE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	dpfm_in_if.sink              in_ch,
	dpfm_out_if.source           out_ch
);

	localparam int unsigned RATE_W = $clog2(TICK_RATE_HZ + 1);
	localparam int unsigned PROD_W = ML_W + RATE_W;
	localparam int unsigned QUO_W  = (PROD_W > FLOW_W) ? PROD_W : FLOW_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'd0,
		S_PREP = 3'd1,
		S_LOAD = 3'd2,
		S_DIV  = 3'd3,
		S_DONE = 3'd4
	} seq_t;

	seq_t              state_q;
	logic              zero_q;
	logic [CNT_W-1:0]  delta_q;
	logic [PROD_W-1:0] prod_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  total_q;
	logic [FLOW_W-1:0] flow_q;
	logic              counted_q;
	logic              armed_q;

	tick_stat_t        stat;
	logic              step;
	logic              advance;
	logic              load_out;
	logic              div_busy;
	logic [QUO_W-1:0]  quotient;
	logic [CNT_W-1:0]  age;
	logic [FLOW_W-1:0] flow_sat;

	assign step     = in_ch.valid && (state_q == S_IDLE);
	assign advance  = (state_q == S_PREP);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);
	assign age      = stat.tick_cnt - stat.last_tick;

	dpfm_tick u_tick (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.step     (step),
		.pin      (in_ch.pin_level),
		.advance  (advance),
		.stat     (stat)
	);

	dpfm_div #(
		.DVD_W (QUO_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_LOAD),
		.dividend (QUO_W'(prod_q)),
		.divisor  (delta_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_comb begin
		flow_sat = quotient[FLOW_W-1:0];
		if (quotient > QUO_W'(FLOW_MAX)) begin
			flow_sat = FLOW_MAX;
		end
		if (zero_q) begin
			flow_sat = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !out_ch.ready);
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: state_q <= S_LOAD;
				S_LOAD: state_q <= S_DIV;
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PREP) begin
			zero_q  <= (stat.last_tick <= stat.prior_tick) || (age > CNT_W'(stat.stale_limit));
			delta_q <= stat.last_tick - stat.prior_tick;
			prod_q  <= PROD_W'(stat.ml_per_pulse) * PROD_W'(TICK_RATE_HZ);
		end
		if (load_out) begin
			total_q   <= stat.pulse_count;
			flow_q    <= flow_sat;
			counted_q <= stat.counted;
			armed_q   <= stat.armed;
		end
	end

	assign in_ch.ready          = (state_q == S_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.pulse_total   = total_q;
	assign out_ch.flow_ml_per_s = flow_q;
	assign out_ch.pulse_counted = counted_q;
	assign out_ch.armed         = armed_q;

endmodule
